FILE: rtl/adr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adr_pkg
// Shared types and constants for the duplicate removal block: request and
// result payloads, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package adr_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     last_res;
        logic                     overflow;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic scan_step;
        logic decide;
        logic emit_read;
        logic emit_next;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic is_last;
        logic emit_final;
    } status_t;

endpackage

FILE: rtl/adr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adr_ram
// Single-port RAM with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module adr_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/adr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adr_datapath
// Holds the current request, the unique store, its fill count and the
// overflow flag. Scans the store one entry per cycle and drives the results.
// ----------------------------------------------------------------------------
module adr_datapath (
    input  logic            aclk,
    input  logic            aresetn,
    input  adr_pkg::cmd_t   cmd,
    input  adr_pkg::in_t    s_data,
    output adr_pkg::status_t sts,
    output adr_pkg::out_t   m_data
);
    import adr_pkg::*;

    in_t               item_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              drop_reg, drop_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic              hit_reg, hit_next;

    logic              scan_more;
    logic              store_full;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0] ram_rdata;

    assign scan_more  = (rd_idx_reg < count_reg);
    assign store_full = (count_reg == CNT_W'(DEPTH));
    assign ram_we     = cmd.decide && !hit_reg && !store_full;
    assign ram_re     = (cmd.scan_step && scan_more) || cmd.emit_read;
    // Writes go to the first free entry; reads follow the scan index.
    assign ram_addr   = ram_we ? count_reg[ADDR_W-1:0] : rd_idx_reg[ADDR_W-1:0];

    adr_ram #(
        .DATA_W(DATA_W),
        .ADDR_W(ADDR_W)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .re   (ram_re),
        .addr (ram_addr),
        .wdata($unsigned(item_reg.value)),
        .rdata(ram_rdata)
    );

    always_comb begin
        count_next   = count_reg;
        drop_next    = drop_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        hit_next     = hit_reg;
        if (cmd.load_item) begin
            rd_idx_next  = '0;
            cmp_vld_next = 1'b0;
            hit_next     = 1'b0;
        end
        if (cmd.scan_step) begin
            // Read and compare overlap: the entry read last cycle is checked now.
            cmp_vld_next = scan_more;
            if (scan_more) begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            if (cmp_vld_reg && (ram_rdata == $unsigned(item_reg.value))) begin
                hit_next = 1'b1;
            end
        end
        if (cmd.decide) begin
            rd_idx_next = '0;
            if (!hit_reg) begin
                if (store_full) begin
                    drop_next = 1'b1;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
        if (cmd.emit_next) begin
            if (sts.emit_final) begin
                count_next = '0;
                drop_next  = 1'b0;
            end else begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            count_reg   <= count_next;
            drop_reg    <= drop_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
    end

    assign sts.scan_done  = !scan_more && !cmp_vld_reg;
    assign sts.is_last    = item_reg.last;
    assign sts.emit_final = ((rd_idx_reg + CNT_W'(1)) == count_reg);

    assign m_data.value_res = signed'(ram_rdata);
    assign m_data.last_res  = sts.emit_final;
    assign m_data.overflow  = drop_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("unique count exceeds store depth");

    a_clear_after_list: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_next && sts.emit_final |=> count_reg == '0 && !drop_reg)
        else $error("store not cleared after the final result");

    a_drop_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide && !hit_reg && store_full |=> drop_reg && store_full)
        else $error("new value on a full store not flagged");

    a_emit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_read |-> count_reg != '0 && scan_more)
        else $error("result read outside the filled part of the store");

endmodule

FILE: rtl/adr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adr_ctrl
// Sequencer: takes a request, runs the store scan, appends or drops the
// value and, after the last request of a list, walks out the results.
// ----------------------------------------------------------------------------
module adr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  adr_pkg::status_t sts,
    output adr_pkg::cmd_t    cmd
);
    import adr_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (sts.scan_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = sts.is_last ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (m_ready) begin
                    state_next = sts.emit_final ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd     = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            ST_SEARCH: begin
                cmd.scan_step = 1'b1;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
            end
            ST_EMIT_RD: begin
                cmd.emit_read = 1'b1;
            end
            ST_EMIT_OUT: begin
                m_valid       = 1'b1;
                cmd.emit_next = m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/array_duplicate_removal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_duplicate_removal
// Keeps the first occurrence of each value of a list and returns the unique
// values in arrival order once the last request of the list has been taken.
// ----------------------------------------------------------------------------
// Each request is compared against the stored unique values through a single
// read port, one entry per cycle, so a request holds the block until all
// stored values have been checked. After the request marked last, the unique
// values come out one by one, each read from the store before it is offered,
// the final one marked, with the overflow bit set on all of them if any new
// value found the 64-entry store full and was dropped. The block then clears
// itself and takes the next list; no request is taken while results go out.
// ----------------------------------------------------------------------------
module array_duplicate_removal (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  adr_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output adr_pkg::out_t m_data
);
    import adr_pkg::*;

    cmd_t    cmd;
    status_t sts;

    adr_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    adr_datapath u_datapath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .s_data (s_data),
        .sts    (sts),
        .m_data (m_data)
    );

endmodule

FILE: tb/tb_array_duplicate_removal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_duplicate_removal
// Self-checking bench for the duplicate removal block. Lists of requests go in
// with random gaps on both channels. A model of the unique value store in the
// bench predicts the values returned after each list's last request, and the
// bench checks every returned value field by field. Short lists with repeats
// make up most of the random part. Some lists run the store past its depth to
// exercise the overflow flag.
// ----------------------------------------------------------------------------
module tb_array_duplicate_removal;
    import adr_pkg::*;

    localparam int GAP_MAX         = 17;
    localparam int RANDOM_REQUESTS = 450;
    localparam int DRAIN_CYCLES    = 200;

    localparam logic signed [31:0] MIN_V = 32'sh8000_0000;
    localparam logic signed [31:0] MAX_V = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               typed;
        logic signed [31:0] exp_value;
    } stim_row_t;

    // Rows that are marked as typed are one-request lists. Their single result
    // is simply the request value, and no overflow can occur.
    localparam int NUM_DIRECTED = 20;
    stim_row_t directed [NUM_DIRECTED] = '{
        '{MIN_V,            1'b1, 1'b1, MIN_V},
        '{MAX_V,            1'b1, 1'b1, MAX_V},
        '{32'sd0,           1'b1, 1'b1, 32'sd0},
        '{-32'sd1,          1'b1, 1'b1, -32'sd1},
        '{32'sd7,           1'b0, 1'b0, 32'sd0},
        '{32'sd7,           1'b0, 1'b0, 32'sd0},
        '{-32'sd7,          1'b0, 1'b0, 32'sd0},
        '{32'sd7,           1'b0, 1'b0, 32'sd0},
        '{-32'sd7,          1'b1, 1'b0, 32'sd0},
        '{MIN_V,            1'b0, 1'b0, 32'sd0},
        '{MAX_V,            1'b0, 1'b0, 32'sd0},
        '{32'sd0,           1'b0, 1'b0, 32'sd0},
        '{-32'sd1,          1'b0, 1'b0, 32'sd0},
        '{MIN_V,            1'b1, 1'b0, 32'sd0},
        '{32'sh5555_5555,   1'b0, 1'b0, 32'sd0},
        '{32'shAAAA_AAAA,   1'b0, 1'b0, 32'sd0},
        '{32'sh5555_5555,   1'b0, 1'b0, 32'sd0},
        '{32'shAAAA_AAAA,   1'b1, 1'b0, 32'sd0},
        '{32'sd1,           1'b0, 1'b0, 32'sd0},
        '{32'sd1,           1'b1, 1'b0, 32'sd0}
    };

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Model of the unique value store
    logic [31:0] uniq_vals [DEPTH];
    int          uniq_count   = 0;
    bit          uniq_dropped = 1'b0;
    out_t        expected_uniques [$];

    int mismatches     = 0;
    int requests_sent  = 0;
    int lists_done     = 0;
    int overflow_lists = 0;
    int results_seen   = 0;
    int send_calm      = 0;
    int recv_calm      = 0;

    array_duplicate_removal u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // A calm stretch gives a run of back-to-back transfers.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    // Folds one accepted value into the store. When the list closes, the
    // function queues the unique values in first-occurrence order.
    function automatic void fold_into_unique_set(input logic [31:0] v, input logic is_last);
        bit   found;
        int   k;
        out_t res;
        found = 1'b0;
        for (k = 0; k < uniq_count; k++) begin
            if (uniq_vals[k] == v)
                found = 1'b1;
        end
        if (!found) begin
            if (uniq_count < DEPTH) begin
                uniq_vals[uniq_count] = v;
                uniq_count++;
            end else begin
                uniq_dropped = 1'b1;
            end
        end
        if (is_last) begin
            for (k = 0; k < uniq_count; k++) begin
                res.value_res = uniq_vals[k];
                res.last_res  = (k == uniq_count - 1);
                res.overflow  = uniq_dropped;
                expected_uniques.push_back(res);
            end
            lists_done++;
            if (uniq_dropped)
                overflow_lists++;
            uniq_count   = 0;
            uniq_dropped = 1'b0;
        end
    endfunction

    task automatic push_request(input logic signed [31:0] value, input logic last);
        int   gap;
        in_t  req;
        gap       = draw_wait(send_calm);
        req.value = value;
        req.last  = last;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        fold_into_unique_set(value, last);
        requests_sent++;
    endtask

    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_uniques.size() == 0) begin
                report_mismatch($sformatf("unexpected result, value %0d", m_data.value_res));
            end else begin
                want = expected_uniques.pop_front();
                if (m_data.value_res !== want.value_res)
                    report_mismatch($sformatf("value_res %0d, expected %0d",
                                              m_data.value_res, want.value_res));
                if (m_data.last_res !== want.last_res)
                    report_mismatch($sformatf("last_res %b, expected %b (value %0d)",
                                              m_data.last_res, want.last_res, want.value_res));
                if (m_data.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, expected %b (value %0d)",
                                              m_data.overflow, want.overflow, want.value_res));
            end
        end
    end

    initial begin : result_side
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = draw_wait(recv_calm);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : request_side
        int          kind;
        int          len;
        int          n_fresh;
        int          n_rep;
        int          fresh_total;
        int          rep_total;
        int          pool_size;
        logic [31:0] base;
        logic [31:0] stride;
        logic [31:0] v;
        logic [31:0] pool [4];

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            push_request(directed[i].value, directed[i].last);
            if (directed[i].typed)
                expected_uniques[expected_uniques.size() - 1] =
                    '{directed[i].exp_value, 1'b1, 1'b0};
        end

        while (requests_sent < NUM_DIRECTED + RANDOM_REQUESTS) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                // The store fills to near or past its depth, with repeats mixed in.
                // Some repeats come after the store is full.
                fresh_total = $urandom_range(DEPTH - 2, DEPTH + 6);
                rep_total   = $urandom_range(0, 6);
                base        = $urandom;
                stride      = $urandom | 32'd1;
                n_fresh     = 0;
                n_rep       = 0;
                while (n_fresh < fresh_total || n_rep < rep_total) begin
                    if (n_rep < rep_total && n_fresh > 0 &&
                        ($urandom_range(0, 3) == 0 || n_fresh == fresh_total)) begin
                        v = base + stride * $urandom_range(0, n_fresh - 1);
                        n_rep++;
                    end else begin
                        v = base + stride * n_fresh;
                        n_fresh++;
                    end
                    push_request(v, (n_fresh + n_rep) == (fresh_total + rep_total));
                end
            end else if (kind < 20) begin
                case ($urandom_range(0, 4))
                    0: v = MIN_V;
                    1: v = MAX_V;
                    2: v = 32'd0;
                    3: v = 32'hFFFF_FFFF;
                    default: v = $urandom;
                endcase
                push_request(v, 1'b1);
            end else begin
                len       = $urandom_range(2, 12);
                pool_size = $urandom_range(1, 4);
                foreach (pool[j])
                    pool[j] = $urandom;
                for (int n = 0; n < len; n++) begin
                    if ($urandom_range(0, 3) == 0)
                        v = $urandom;
                    else
                        v = pool[$urandom_range(0, pool_size - 1)];
                    push_request(v, n == len - 1);
                end
            end
        end
        s_valid <= 1'b0;

        while (expected_uniques.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests in %0d lists, %0d of which overflowed the store.",
                 requests_sent, lists_done, overflow_lists);
        $display("Checked %0d unique values and found %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #30_000_000;
        $display("Timed out with %0d results still outstanding.", expected_uniques.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
